[rtl/assert_macros.svh]
// Assertion helper macros shared by the RTL.
// No dependencies; the macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: lbl");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");
`else
`define ASSERT_NEVER(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/chte_pkg.sv]
// Constants and codes of the chained hash table engine.
// No dependencies.
package chte_pkg;
   localparam logic [26:0] HASH_MUL   = 27'h45d9f3b;
   localparam int          HASH_SHIFT = 16;
   localparam int          KEY_W      = 64;
   localparam int          DATA_W     = 32;
   localparam int          CNT_W      = 9;
   localparam int          MOD_BITS   = 4;
   localparam int          MOD_STEPS  = KEY_W / MOD_BITS;

   localparam logic [1:0] OP_PUT = 2'd0;
   localparam logic [1:0] OP_GET = 2'd1;
   localparam logic [1:0] OP_SET = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DUP     = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;
endpackage

[rtl/chained_hash_table_engine_core.sv]
// Top level of the chained hash table engine: sequencer, key/value/fill stores.
// Depends on chte_pkg, chte_hash and assert_macros.svh.
//
//  Channel | Ports            | Contents
//  --------+------------------+------------------------------------------
//  request | req_t*           | tdata key, value; tuser operation
//  result  | rsp_t*           | tdata read_value; tuser found, status
//  config  | csr_wr_*         | bucket_count
//
// The request passes the hash (mixing rounds on the shared multiplier, then
// the 64-bit remainder retiring four bits a cycle), the fill read, a scan
// that reads and compares one stored key at a time, the value read and the
// result register. Operation three answers straight from idle, without
// hashing. req_tready is high only when idle, which it is again in the cycle
// after the result transfer; a result holds in rsp_tdata/rsp_tuser until
// taken. Synchronous reset clears all fill counts at once through per-bucket valid bits.
`include "assert_macros.svh"
module chained_hash_table_engine_core #(
   parameter int MAX_BUCKETS        = 256,
   parameter int ENTRIES_PER_BUCKET = 8,
   parameter int VALUE_WIDTH        = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // key [63:0], value [95:64]
   input  logic [1:0]  req_tuser,   // operation [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value [31:0]
   output logic [2:0]  rsp_tuser,   // found [0], status [2:1]
   input  logic        csr_wr_en,
   input  logic [chte_pkg::CNT_W-1:0] csr_wr_data
);
   import chte_pkg::*;

   localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SLOTS  = MAX_BUCKETS * ENTRIES_PER_BUCKET;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int FILL_W = $clog2(ENTRIES_PER_BUCKET + 1);

   typedef enum logic [3:0] {
      T_IDLE, T_HASH, T_FILL, T_SCAN, T_CMP, T_ACT, T_VAL, T_OUT
   } tstate_type;

   tstate_type              state_ff;
   logic [CNT_W-1:0]        bcount_ff;
   logic [1:0]              op_ff;
   logic [KEY_W-1:0]        key_ff;
   logic [VALUE_WIDTH-1:0]  val_ff;
   logic [BKT_W-1:0]        bucket_ff;
   logic [FILL_W-1:0]       idx_ff;
   logic                    hit_ff;
   logic [FILL_W-1:0]       fill_rd_ff;
   logic                    vld_rd_ff;
   logic [KEY_W-1:0]        key_rd_ff;
   logic [VALUE_WIDTH-1:0]  val_rd_ff;
   logic                    rsp_valid_ff;
   logic [31:0]             rsp_data_ff;
   logic [2:0]              rsp_user_ff;

   logic [KEY_W-1:0]        key_mem [SLOTS];
   logic [VALUE_WIDTH-1:0]  val_mem [SLOTS];
   logic [FILL_W-1:0]       fill_mem [MAX_BUCKETS];
   logic [MAX_BUCKETS-1:0]  fill_vld_ff;

   logic                    accept, hash_start, hash_done;
   logic [BKT_W-1:0]        hash_bucket;
   logic [16:0]             n_clamp;
   logic [BKT_W-1:0]        divisor;
   logic [FILL_W-1:0]       fill_eff;
   logic [ADDR_W-1:0]       addr;
   logic                    is_full;
   logic                    do_insert, do_update;

   assign accept     = req_tvalid && req_tready;
   assign hash_start = accept && (req_tuser != OP_NOP);

   // Clamp the configured count into [2, MAX_BUCKETS]; the divisor is one less.
   always_comb begin
      n_clamp = 17'(bcount_ff);
      if (n_clamp < 17'd2) n_clamp = 17'd2;
      if (n_clamp > 17'(MAX_BUCKETS)) n_clamp = 17'(MAX_BUCKETS);
      divisor = BKT_W'(n_clamp - 17'd1);
   end

   chte_hash #(.BKT_W(BKT_W)) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (req_tdata[63:0]),
      .divisor (divisor),
      .done    (hash_done),
      .bucket  (hash_bucket)
   );

   assign fill_eff  = vld_rd_ff ? fill_rd_ff : '0;
   assign is_full   = (fill_eff >= FILL_W'(ENTRIES_PER_BUCKET));
   assign addr      = ADDR_W'(ADDR_W'(bucket_ff) * ADDR_W'(ENTRIES_PER_BUCKET)
                              + ADDR_W'(idx_ff));
   assign do_insert = (state_ff == T_ACT) && (op_ff == OP_PUT) && !hit_ff && !is_full;
   assign do_update = (state_ff == T_ACT) && (op_ff == OP_SET) && hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         bcount_ff    <= CNT_W'(256);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) bcount_ff <= csr_wr_data;
         unique case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  op_ff  <= req_tuser;
                  key_ff <= req_tdata[63:0];
                  val_ff <= VALUE_WIDTH'(req_tdata[95:64]);
                  hit_ff <= 1'b0;
                  idx_ff <= '0;
                  if (req_tuser == OP_NOP) begin
                     rsp_data_ff  <= '0;
                     rsp_user_ff  <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= T_OUT;
                  end else begin
                     state_ff <= T_HASH;
                  end
               end
            end
            T_HASH: begin
               if (hash_done) begin
                  bucket_ff <= hash_bucket;
                  state_ff  <= T_FILL;
               end
            end
            T_FILL: begin
               fill_rd_ff <= fill_mem[bucket_ff];
               vld_rd_ff  <= fill_vld_ff[bucket_ff];
               state_ff   <= T_SCAN;
            end
            T_SCAN: begin
               if (idx_ff < fill_eff) begin
                  key_rd_ff <= key_mem[addr];
                  state_ff  <= T_CMP;
               end else begin
                  state_ff <= T_ACT;
               end
            end
            T_CMP: begin
               if (key_rd_ff == key_ff) begin
                  hit_ff   <= 1'b1;
                  state_ff <= T_ACT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= T_SCAN;
               end
            end
            T_ACT: begin
               val_rd_ff <= val_mem[addr];
               state_ff  <= T_VAL;
            end
            T_VAL: begin
               rsp_data_ff    <= (op_ff == OP_GET && hit_ff) ? 32'(val_rd_ff) : 32'd0;
               rsp_user_ff[0] <= hit_ff;
               case (op_ff)
                  OP_PUT:  rsp_user_ff[2:1] <= hit_ff ? ST_DUP : (is_full ? ST_FULL : ST_OK);
                  OP_SET:  rsp_user_ff[2:1] <= hit_ff ? ST_OK : ST_MISSING;
                  default: rsp_user_ff[2:1] <= ST_OK;
               endcase
               rsp_valid_ff <= 1'b1;
               state_ff     <= T_OUT;
            end
            T_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   // Stores: the slot address points at the match on set, or past the last
   // used slot on put.
   always_ff @(posedge clock) begin
      if (do_insert) key_mem[addr] <= key_ff;
      if (do_insert || do_update) val_mem[addr] <= val_ff;
      if (do_insert) fill_mem[bucket_ff] <= fill_eff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff <= '0;
      end else if (do_insert) begin
         fill_vld_ff[bucket_ff] <= 1'b1;
      end
   end

   assign req_tready = (state_ff == T_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_NEVER(a_ready_while_pending, clock, reset, req_tready && rsp_tvalid)
   `ASSERT_IMPLIES(a_dup_is_found, clock, reset,
      rsp_tvalid && rsp_tuser[2:1] == ST_DUP, rsp_tuser[0])
   `ASSERT_IMPLIES(a_missing_not_found, clock, reset,
      rsp_tvalid && (rsp_tuser[2:1] == ST_MISSING || rsp_tuser[2:1] == ST_FULL),
      !rsp_tuser[0])
   `ASSERT_IMPLIES(a_value_needs_hit, clock, reset,
      rsp_tvalid && rsp_tdata != 32'd0, rsp_tuser[0])
endmodule

[rtl/chte_hash.sv]
// Key mixer and bucket reduction over one shared 32x27 multiplier and a
// four-bit-per-cycle restoring remainder. Depends on chte_pkg.
module chte_hash #(
   parameter int BKT_W = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [chte_pkg::KEY_W-1:0] key,
   input  logic [BKT_W-1:0]         divisor,
   output logic                     done,
   output logic [BKT_W-1:0]         bucket
);
   import chte_pkg::*;

   localparam int STEP_W = $clog2(MOD_STEPS);

   typedef enum logic [1:0] {H_IDLE, H_MLO, H_MHI, H_MOD} hstate_type;

   hstate_type        state_ff, state_in;
   logic [KEY_W-1:0]  x_ff, x_in;
   logic [58:0]       prod_ff, prod_in;
   logic              round_ff, round_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [BKT_W-1:0]  rem_ff, rem_in;
   logic [BKT_W-1:0]  div_ff, div_in;
   logic              done_ff, done_in;

   logic [31:0]       mul_a;
   logic [58:0]       mul_p;
   logic [KEY_W-1:0]  sum;
   logic [BKT_W:0]    r;

   assign mul_a = (state_ff == H_MLO) ? x_ff[31:0] : x_ff[63:32];
   assign mul_p = 59'(mul_a) * 59'(HASH_MUL);
   // Low half product plus the high half product moved up 32 bits, mod 2^64.
   assign sum   = KEY_W'(prod_ff) + {mul_p[31:0], 32'd0};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      prod_in  = prod_ff;
      round_in = round_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      r        = '0;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               x_in     = (key >> HASH_SHIFT) ^ key;
               div_in   = divisor;
               round_in = 1'b0;
               state_in = H_MLO;
            end
         end
         H_MLO: begin
            prod_in  = mul_p;
            state_in = H_MHI;
         end
         H_MHI: begin
            x_in = (sum >> HASH_SHIFT) ^ sum;
            if (!round_ff) begin
               round_in = 1'b1;
               state_in = H_MLO;
            end else begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = H_MOD;
            end
         end
         H_MOD: begin
            r = {1'b0, rem_ff};
            for (int i = 0; i < MOD_BITS; i++) begin
               r = {r[BKT_W-1:0], x_ff[KEY_W-1-i]};
               if (r >= {1'b0, div_ff}) r = r - {1'b0, div_ff};
            end
            rem_in = r[BKT_W-1:0];
            x_in   = x_ff << MOD_BITS;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(MOD_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = H_IDLE;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff     <= x_in;
      prod_ff  <= prod_in;
      round_ff <= round_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;
endmodule
